// ===== design/fshc_pkg.sv =====
// ============================================================================
// fshc_pkg - shared definitions for the floppy head seek controller
// Phase codes, command codes, register indexes, reset values and the
// structures that pass configuration and status between the modules.
// ============================================================================
package fshc_pkg;

    // Fixed widths of the word fields and registers.
    localparam int TRACK_FIELD_W = 8;
    localparam int TIMER_FIELD_W = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 16;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 16;

    // Defaults for the top-level parameters.
    localparam int TRACK_BITS_DEF = 8;
    localparam int TIMER_BITS_DEF = 16;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ZWAIT   = 3'd1;
    localparam logic [2:0] PH_RPULSE  = 3'd2;
    localparam logic [2:0] PH_RSETTLE = 3'd3;
    localparam logic [2:0] PH_SPULSE  = 3'd4;
    localparam logic [2:0] PH_SSETTLE = 3'd5;
    localparam logic [2:0] PH_SNEXT   = 3'd6;

    // Commands carried with each tick.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SEEK  = 2'd1;
    localparam logic [1:0] CMD_RECAL = 2'd2;
    localparam logic [1:0] CMD_SIDE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRACKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WAIT   = 3'd4;

    // Register values after reset.
    localparam logic [7:0]  RST_MAX_TRACKS  = 8'd80;
    localparam logic        RST_DOUBLE_STEP = 1'b0;
    localparam logic [7:0]  RST_STEP_PULSE  = 8'd8;
    localparam logic [15:0] RST_SETTLE      = 16'd40000;
    localparam logic [15:0] RST_ZERO_WAIT   = 16'd10000;

    // Bit positions in the result word.
    localparam int OUT_STEP_BIT = 0;
    localparam int OUT_BUSY_BIT = 3;

    typedef struct packed {
        logic [7:0]  max_tracks;
        logic        double_step;
        logic [7:0]  step_pulse_ticks;
        logic [15:0] settle_ticks;
        logic [15:0] zero_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic                     rejected;
        logic [TRACK_FIELD_W-1:0] track_now;
        logic                     busy_res;
        logic                     side_out;
        logic                     direction_in;
        logic                     step_out;
    } t_res;

endpackage

// ===== design/fshc_seq.sv =====
// ============================================================================
// fshc_seq - step and seek sequencer
// Holds the head position and phase state and advances it by one tick for
// every accepted word, producing the status seen after that tick.
// ============================================================================
module fshc_seq
    import fshc_pkg::*;
#(
    parameter int TRACK_BITS = TRACK_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  logic [1:0]               i_command,
    input  logic [TRACK_FIELD_W-1:0] i_target_track,
    input  logic                     i_side,
    input  logic                     i_at_track_zero,
    input  t_cfg                     i_cfg,
    output t_res                     o_res
);

    logic [2:0]            r_phase, n_phase;
    logic [TRACK_BITS-1:0] r_track, n_track;
    logic [TRACK_BITS-1:0] r_goal, n_goal;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic                  r_pulse_idx, n_pulse_idx;
    logic                  r_inward, n_inward;
    logic                  r_side, n_side;

    logic                  rejected;
    logic                  do_pulse;
    logic                  range_bad;
    logic [TRACK_BITS-1:0] target;
    logic [TIMER_BITS-1:0] pulse_load, settle_load, zero_load;

    assign target      = TRACK_BITS'(i_target_track);
    assign pulse_load  = TIMER_BITS'(i_cfg.step_pulse_ticks);
    assign settle_load = TIMER_BITS'(i_cfg.settle_ticks);
    assign zero_load   = TIMER_BITS'(i_cfg.zero_wait_ticks);
    assign range_bad   = (i_target_track >= i_cfg.max_tracks)
                       || (TRACK_FIELD_W'(r_track) >= i_cfg.max_tracks)
                       || ((i_target_track >> TRACK_BITS) != '0);

    always_comb begin
        n_phase     = r_phase;
        n_track     = r_track;
        n_goal      = r_goal;
        n_timer     = r_timer;
        n_pulse_idx = r_pulse_idx;
        n_inward    = r_inward;
        n_side      = r_side;
        rejected    = 1'b0;
        do_pulse    = 1'b0;

        if (r_phase != PH_IDLE) begin
            rejected = (i_command != CMD_TICK);
            if ((r_phase != PH_SNEXT) && (r_timer > TIMER_BITS'(1))) begin
                n_timer = r_timer - TIMER_BITS'(1);
            end else begin
                n_timer = '0;
                unique case (r_phase)
                    PH_ZWAIT, PH_RSETTLE: begin
                        if (i_at_track_zero) begin
                            n_track = '0;
                            n_goal  = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_inward = 1'b0;
                            n_phase  = PH_RPULSE;
                            n_timer  = pulse_load;
                        end
                    end
                    PH_RPULSE: begin
                        n_phase = PH_RSETTLE;
                        n_timer = settle_load;
                    end
                    PH_SPULSE: begin
                        n_phase = PH_SSETTLE;
                        n_timer = settle_load;
                    end
                    PH_SSETTLE: begin
                        if (i_cfg.double_step && !r_pulse_idx) begin
                            n_pulse_idx = 1'b1;
                            do_pulse    = 1'b1;
                        end else begin
                            n_pulse_idx = 1'b0;
                            n_track = r_inward ? r_track + TRACK_BITS'(1)
                                               : r_track - TRACK_BITS'(1);
                            if (n_track == r_goal) begin
                                n_phase = PH_IDLE;
                            end else begin
                                do_pulse = 1'b1;
                            end
                        end
                    end
                    PH_SNEXT: begin
                        do_pulse = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else begin
            unique case (i_command)
                CMD_SEEK: begin
                    if (range_bad) begin
                        rejected = 1'b1;
                    end else if (target == '0) begin
                        n_inward    = 1'b0;
                        n_pulse_idx = 1'b0;
                        n_phase     = PH_ZWAIT;
                        n_timer     = zero_load;
                    end else if (target != r_track) begin
                        n_goal      = target;
                        n_inward    = (target > r_track);
                        n_pulse_idx = 1'b0;
                        do_pulse    = 1'b1;
                    end
                end
                CMD_RECAL: begin
                    n_inward    = 1'b0;
                    n_pulse_idx = 1'b0;
                    n_phase     = PH_ZWAIT;
                    n_timer     = zero_load;
                end
                CMD_SIDE: begin
                    n_side = i_side;
                end
                default: begin
                end
            endcase
        end

        // Start the next step pulse; an outward pulse with the head already
        // on track zero is dropped and the track is counted off at once.
        if (do_pulse) begin
            if (!n_inward && i_at_track_zero) begin
                n_track     = n_track - TRACK_BITS'(1);
                n_pulse_idx = 1'b0;
                n_timer     = '0;
                n_phase     = (n_track == n_goal) ? PH_IDLE : PH_SNEXT;
            end else begin
                n_phase = PH_SPULSE;
                n_timer = pulse_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_track     <= '0;
            r_goal      <= '0;
            r_timer     <= '0;
            r_pulse_idx <= 1'b0;
            r_inward    <= 1'b0;
            r_side      <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_track     <= n_track;
            r_goal      <= n_goal;
            r_timer     <= n_timer;
            r_pulse_idx <= n_pulse_idx;
            r_inward    <= n_inward;
            r_side      <= n_side;
        end
    end

    assign o_res.step_out     = (n_phase == PH_RPULSE) || (n_phase == PH_SPULSE);
    assign o_res.direction_in = n_inward;
    assign o_res.side_out     = n_side;
    assign o_res.busy_res     = (n_phase != PH_IDLE);
    assign o_res.track_now    = TRACK_FIELD_W'(n_track);
    assign o_res.rejected     = rejected;

endmodule

// ===== design/floppy_head_seek_controller_core.sv =====
// ============================================================================
// floppy_head_seek_controller_core - floppy drive step and seek controller
// Turns seek, recalibrate and side-select commands into step pulses, a
// direction line and a side line, one timing tick per input word.
// ============================================================================
// Usage:
// Every word on the slave stream is one timing tick of the step sequencer and
// may carry a command in tuser (tick only, seek, recalibrate, select side).
// tdata carries the seek target, the requested side and the decoded
// track-zero sensor. For every accepted word exactly one result word leaves
// on the master stream, giving the drive lines, busy, the believed track and
// whether this tick's command was turned away.
// The result of an accepted word is registered and valid in the cycle after it
// is accepted. Throughput is one word per cycle while the receiver keeps up;
// the sequencer state and the output register update together in the
// accepting cycle.
// If the receiver stalls, the result register holds its word and tready on
// the slave side drops until that word is taken; while the output register
// is empty or being emptied a new word is taken in every cycle.
// Reset (synchronous, active low) puts the head state at track zero, side 0,
// idle, empties the output register and loads the register defaults: 80
// tracks, single stepping, 8 tick pulses, 40000 tick settle, 10000 tick
// recalibrate wait. Registers are written through the plain write port; the user
// must write them only while the block is idle, the block does not enforce it.
// ============================================================================
module floppy_head_seek_controller_core
    import fshc_pkg::*;
#(
    parameter int TRACK_BITS = TRACK_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Slave stream: one tick per word.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] target_track, [8] side, [9] at_track_zero, [15:10] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [IN_USER_W-1:0]  s_axis_tuser,

    // Master stream: one result word per tick.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] step_out, [1] direction_in, [2] side_out, [3] busy_res,
    // [11:4] track_now, [12] rejected, [15:13] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                  r_cfg;
    t_res                  seq_res;
    logic                  in_accept;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // The output register may be refilled in the same cycle it is emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_tracks       <= RST_MAX_TRACKS;
            r_cfg.double_step      <= RST_DOUBLE_STEP;
            r_cfg.step_pulse_ticks <= RST_STEP_PULSE;
            r_cfg.settle_ticks     <= RST_SETTLE;
            r_cfg.zero_wait_ticks  <= RST_ZERO_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_TRACKS:  r_cfg.max_tracks       <= i_cfg_wdata[7:0];
                CFG_DOUBLE_STEP: r_cfg.double_step      <= i_cfg_wdata[0];
                CFG_STEP_PULSE:  r_cfg.step_pulse_ticks <= i_cfg_wdata[7:0];
                CFG_SETTLE:      r_cfg.settle_ticks     <= i_cfg_wdata[15:0];
                CFG_ZERO_WAIT:   r_cfg.zero_wait_ticks  <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer advances its state by one tick for each accepted word and
    // reports the status after that tick.
    fshc_seq #(
        .TRACK_BITS (TRACK_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (in_accept),
        .i_command       (s_axis_tuser[1:0]),
        .i_target_track  (s_axis_tdata[7:0]),
        .i_side          (s_axis_tdata[8]),
        .i_at_track_zero (s_axis_tdata[9]),
        .i_cfg           (r_cfg),
        .o_res           (seq_res)
    );

    // Result register: valid is control state, the word itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= {3'b000, seq_res.rejected, seq_res.track_now,
                           seq_res.busy_res, seq_res.side_out,
                           seq_res.direction_in, seq_res.step_out};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Every accepted tick must leave a result word in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted tick produced no result word");

    // A waiting result must never be overwritten by a new tick.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("new tick accepted over a stalled result word");

    // A step pulse is only ever driven while a seek or recalibrate runs.
    a_step_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_STEP_BIT]) |-> m_axis_tdata[OUT_BUSY_BIT])
        else $error("step pulse reported while idle");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking testbench for the floppy head seek controller
// Feeds tick words, each perhaps carrying a seek, recalibrate or side
// command, keeps a tick-exact model of the step sequencer alongside, and
// compares every result word field by field with the model's prediction
// under several register settings and idling patterns.
// ============================================================================
module tb_top;
    import fshc_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int REPORT_LIMIT = 10;

    // One tick word as the sender sees it.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] target;
        logic       side;
        logic       tz;
    } t_tick;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    floppy_head_seek_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the registers and of the sequencer state. Both start at
    // their reset values; reset is applied only once, so no reload is needed.
    // ------------------------------------------------------------------------
    logic [7:0]  cfg_max_tracks  = RST_MAX_TRACKS;
    logic        cfg_double_step = RST_DOUBLE_STEP;
    logic [7:0]  cfg_pulse_ticks = RST_STEP_PULSE;
    logic [15:0] cfg_settle      = RST_SETTLE;
    logic [15:0] cfg_zero_wait   = RST_ZERO_WAIT;

    logic [2:0]  hd_phase  = PH_IDLE;
    logic [7:0]  hd_track  = '0;
    logic [7:0]  hd_goal   = '0;
    logic [15:0] hd_timer  = '0;
    logic        hd_second = 1'b0;
    logic        hd_inward = 1'b0;
    logic        hd_side   = 1'b0;

    t_tick tick_pending[$];
    t_res  expected_status[$];
    t_tick drv_word = '0;
    t_res  drv_predicted;
    t_res  mon_expected;
    t_res  mon_got;

    int error_count  = 0;
    int cycle_count  = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    task automatic head_load(input logic [2:0] ph, input logic [15:0] ticks);
        hd_phase = ph;
        hd_timer = ticks;
    endtask

    task automatic head_start_recal();
        hd_inward = 1'b0;
        hd_second = 1'b0;
        head_load(PH_ZWAIT, cfg_zero_wait);
    endtask

    // Starts one step pulse. An outward pulse while the sensor reports track
    // zero is not issued: the track still counts down and the sequencer either
    // stops at the goal or picks up the next track on the following tick.
    task automatic head_begin_pulse(input logic tz);
        if (!hd_inward && tz) begin
            hd_track  = hd_track - 8'd1;
            hd_second = 1'b0;
            if (hd_track == hd_goal) begin
                head_load(PH_IDLE, '0);
            end else begin
                head_load(PH_SNEXT, '0);
            end
        end else begin
            head_load(PH_SPULSE, {8'd0, cfg_pulse_ticks});
        end
    endtask

    // Called when the settle wait after a seek pulse has run out.
    task automatic head_pulse_done(input logic tz);
        if (cfg_double_step && !hd_second) begin
            hd_second = 1'b1;
            head_begin_pulse(tz);
        end else begin
            hd_second = 1'b0;
            hd_track  = hd_inward ? hd_track + 8'd1 : hd_track - 8'd1;
            if (hd_track == hd_goal) begin
                head_load(PH_IDLE, '0);
            end else begin
                head_begin_pulse(tz);
            end
        end
    endtask

    // One tick of a running sequence. A timer of zero or one ends the phase
    // on this tick, so a zero tick count behaves as one.
    task automatic head_advance(input logic tz);
        if (hd_phase != PH_SNEXT && hd_timer > 16'd1) begin
            hd_timer = hd_timer - 16'd1;
        end else begin
            hd_timer = '0;
            case (hd_phase)
                PH_ZWAIT, PH_RSETTLE: begin
                    if (tz) begin
                        hd_track = '0;
                        hd_goal  = '0;
                        head_load(PH_IDLE, '0);
                    end else begin
                        hd_inward = 1'b0;
                        head_load(PH_RPULSE, {8'd0, cfg_pulse_ticks});
                    end
                end
                PH_RPULSE: head_load(PH_RSETTLE, cfg_settle);
                PH_SPULSE: head_load(PH_SSETTLE, cfg_settle);
                PH_SSETTLE: head_pulse_done(tz);
                PH_SNEXT: head_begin_pulse(tz);
                default: head_load(PH_IDLE, '0);
            endcase
        end
    endtask

    // Applies one accepted tick word and gives the status that follows it.
    task automatic head_tick(input t_tick w, output t_res r);
        logic rej;
        rej = 1'b0;
        if (hd_phase != PH_IDLE) begin
            // Any real command while busy is turned away; the sequence runs on.
            if (w.cmd != CMD_TICK) rej = 1'b1;
            head_advance(w.tz);
        end else begin
            case (w.cmd)
                CMD_SEEK: begin
                    if (w.target >= cfg_max_tracks || hd_track >= cfg_max_tracks) begin
                        rej = 1'b1;
                    end else if (w.target == 8'd0) begin
                        head_start_recal();
                    end else if (w.target != hd_track) begin
                        hd_goal   = w.target;
                        hd_inward = w.target > hd_track;
                        hd_second = 1'b0;
                        head_begin_pulse(w.tz);
                    end
                end
                CMD_RECAL: head_start_recal();
                CMD_SIDE: hd_side = w.side;
                default: ;
            endcase
        end
        r.step_out     = (hd_phase == PH_RPULSE) || (hd_phase == PH_SPULSE);
        r.direction_in = hd_inward;
        r.side_out     = hd_side;
        r.busy_res     = hd_phase != PH_IDLE;
        r.track_now    = hd_track;
        r.rejected     = rej;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued tick words, with random gaps when asked. The
    // prediction is made at the edge where the word is accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                head_tick(drv_word, drv_predicted);
                expected_status.push_back(drv_predicted);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tick_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    drv_word = tick_pending.pop_front();
                    s_axis_tdata  <= {6'd0, drv_word.tz, drv_word.side, drv_word.target};
                    s_axis_tuser  <= drv_word.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result words, with random stalls when asked, and checks
    // each against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_status.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_LIMIT)
                        $display("result word %h arrived with nothing expected", m_axis_tdata);
                end else begin
                    mon_expected = expected_status.pop_front();
                    mon_got      = m_axis_tdata[$bits(t_res)-1:0];
                    if (mon_got != mon_expected) begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_LIMIT)
                            $display({"status mismatch: step %0b/%0b dir %0b/%0b side %0b/%0b",
                                      " busy %0b/%0b track %0d/%0d rejected %0b/%0b",
                                      " (expected/actual)"},
                                     mon_expected.step_out, mon_got.step_out,
                                     mon_expected.direction_in, mon_got.direction_in,
                                     mon_expected.side_out, mon_got.side_out,
                                     mon_expected.busy_res, mon_got.busy_res,
                                     mon_expected.track_now, mon_got.track_now,
                                     mon_expected.rejected, mon_got.rejected);
                    end
                end
            end
            m_axis_tready <= $urandom_range(99) >= snk_stall_pct;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] cmd, input logic [7:0] target,
                             input logic side, input logic tz);
        t_tick w;
        w.cmd    = cmd;
        w.target = target;
        w.side   = side;
        w.tz     = tz;
        tick_pending.push_back(w);
    endtask

    // Register writes happen only with nothing in flight, so the shadow copy
    // can follow at once.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_MAX_TRACKS:  cfg_max_tracks  = data[7:0];
            CFG_DOUBLE_STEP: cfg_double_step = data[0];
            CFG_STEP_PULSE:  cfg_pulse_ticks = data[7:0];
            CFG_SETTLE:      cfg_settle      = data;
            CFG_ZERO_WAIT:   cfg_zero_wait   = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_write_all(input int max_tr, input int dbl, input int pulse,
                                 input int settle, input int zwait);
        cfg_write(CFG_MAX_TRACKS, max_tr[15:0]);
        cfg_write(CFG_DOUBLE_STEP, dbl[15:0]);
        cfg_write(CFG_STEP_PULSE, pulse[15:0]);
        cfg_write(CFG_SETTLE, settle[15:0]);
        cfg_write(CFG_ZERO_WAIT, zwait[15:0]);
    endtask

    // Returns once every queued word has been accepted and answered.
    task automatic wait_drained();
        while (tick_pending.size() != 0 || expected_status.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    // Feeds plain ticks until the sequencer is idle again, so that the next
    // register write falls in a quiet block. The track-zero sensor is raised
    // in the given share of those ticks so that a recalibrate always ends.
    task automatic run_to_idle(input int tz_pct);
        wait_drained();
        while (hd_phase != PH_IDLE) begin
            repeat (16)
                push_word(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          $urandom_range(99) < tz_pct);
            wait_drained();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly in-range seeks among plain ticks, with some recalibrates, side
    // selects and out-of-range targets as noise.
    task automatic queue_random_words(input int count);
        t_tick w;
        int    pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60)      w.cmd = CMD_TICK;
            else if (pick < 80) w.cmd = CMD_SEEK;
            else if (pick < 90) w.cmd = CMD_RECAL;
            else                w.cmd = CMD_SIDE;
            if (cfg_max_tracks != 0 && $urandom_range(99) < 85)
                w.target = 8'($urandom_range(int'(cfg_max_tracks) - 1, 0));
            else
                w.target = 8'($urandom_range(255));
            w.side = 1'($urandom_range(1));
            w.tz   = $urandom_range(7) == 0;
            tick_pending.push_back(w);
        end
    endtask

    // One random phase: new settings, new idling, and a pause half way
    // through in which the sender waits for every result to come back.
    task automatic run_random_phase(input int max_tr, input int dbl, input int pulse,
                                    input int settle, input int zwait,
                                    input int src_pct, input int snk_pct, input int count);
        cfg_write_all(max_tr, dbl, pulse, settle, zwait);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        queue_random_words(count / 2);
        wait_drained();
        queue_random_words(count - count / 2);
        run_to_idle(50);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: plain ticks, side selects and seeks past the
        // last supported track, which must be turned away.
        push_word(CMD_TICK, 8'd255, 1'b1, 1'b1);
        push_word(CMD_SIDE, 8'd0, 1'b1, 1'b0);
        push_word(CMD_SIDE, 8'd255, 1'b0, 1'b1);
        push_word(CMD_SEEK, 8'd80, 1'b0, 1'b0);
        push_word(CMD_SEEK, 8'd255, 1'b1, 1'b0);
        run_to_idle(50);

        // Long inward seek to the last track, with commands arriving while busy.
        cfg_write_all(40, 0, 1, 2, 3);
        push_word(CMD_SEEK, 8'd39, 1'b0, 1'b0);
        push_word(CMD_SEEK, 8'd3, 1'b0, 1'b1);
        push_word(CMD_RECAL, 8'd0, 1'b1, 1'b0);
        push_word(CMD_SIDE, 8'd0, 1'b1, 1'b0);
        push_word(CMD_TICK, 8'd0, 1'b0, 1'b0);
        run_to_idle(50);
        // A seek to the track already reached does nothing.
        push_word(CMD_SEEK, 8'd39, 1'b0, 1'b0);

        // Current track beyond a lowered limit: seeks are refused, a
        // recalibrate is still taken and brings the head back to zero.
        wait_drained();
        cfg_write(CFG_MAX_TRACKS, 16'd10);
        push_word(CMD_SEEK, 8'd5, 1'b0, 1'b0);
        push_word(CMD_RECAL, 8'd0, 1'b0, 1'b0);
        run_to_idle(30);
        // A seek to track zero recalibrates.
        push_word(CMD_SEEK, 8'd0, 1'b0, 1'b0);
        run_to_idle(50);

        // Single stepping inward, then double stepping outward with the sensor
        // asserting early so that pulses are skipped.
        push_word(CMD_SEEK, 8'd9, 1'b0, 1'b0);
        run_to_idle(0);
        cfg_write(CFG_DOUBLE_STEP, 16'd1);
        push_word(CMD_SEEK, 8'd2, 1'b0, 1'b0);
        push_word(CMD_TICK, 8'd0, 1'b0, 1'b0);
        push_word(CMD_TICK, 8'd0, 1'b0, 1'b0);
        run_to_idle(100);

        // Zero limit refuses every seek; zero tick counts act as one.
        cfg_write_all(0, 1, 0, 0, 0);
        push_word(CMD_SEEK, 8'd0, 1'b0, 1'b0);
        push_word(CMD_SEEK, 8'd5, 1'b0, 1'b0);
        push_word(CMD_RECAL, 8'd0, 1'b0, 1'b0);
        push_word(CMD_TICK, 8'd0, 1'b0, 1'b0);
        run_to_idle(30);

        // Random phases over a spread of settings and idling patterns.
        run_random_phase(12, 0, 1, 1, 1, 0, 0, 80);
        run_random_phase(20, 1, 2, 3, 3, 45, 0, 80);
        run_random_phase(8, 1, 1, 2, 1, 0, 45, 80);
        run_random_phase($urandom_range(40, 2), $urandom_range(1), $urandom_range(4, 1),
                         $urandom_range(6, 1), $urandom_range(6, 1), 37, 37, 80);
        run_random_phase(1, 0, 40, 1, 1, 37, 37, 80);
        run_random_phase(24, 1, 1, 1, 1, 37, 37, 80);
        run_random_phase(16, 0, 3, 4, 2, 37, 37, 80);

        // Longer timings: one recalibrate and a one-track seek.
        cfg_write_all(255, 0, 20, 30, 25);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        push_word(CMD_RECAL, 8'd0, 1'b0, 1'b0);
        run_to_idle(100);
        push_word(CMD_SEEK, 8'd1, 1'b0, 1'b0);
        run_to_idle(100);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && expected_status.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
